// File: rtl/lcm_pkg.sv
`default_nettype none

package lcm_pkg;

   // Operand width as seen on the ports.
   localparam int DATA_WIDTH = 32;
   // A valid operand has its top bit clear, so the arithmetic works on one bit less.
   localparam int OP_WIDTH   = DATA_WIDTH - 1;
   localparam int PROD_WIDTH = 2 * OP_WIDTH;
   localparam int CNT_WIDTH  = $clog2(OP_WIDTH);
   localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(OP_WIDTH - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic clear;
      logic gdiv_init;
      logic qdiv_init;
      logic div_step;
      logic gcd_shift;
      logic mul_init;
      logic mul_step;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic operands_ok;
      logic y_zero;
   } dp_status_type;

endpackage

`default_nettype wire

// File: rtl/lcm_by_euclid_gcd.sv
`default_nettype none

// Least common multiple of two 32-bit operands by Euclid's greatest common divisor.
// A transaction is accepted on a rising edge where start is high and busy is low; busy
// then stays high until the result has been shown. The result appears for exactly one
// cycle, marked by rsp_strobe, and the receiver cannot stall it, so it must capture the
// result in that cycle. An operand that is zero or has its top bit set makes all result
// fields zero, and that answer is shown straight after the check state. For valid
// operands, Euclid's loop takes at most about 45 remainder steps for 31-bit operands.
// Every remainder, and the final quotient, comes from one shared restoring divider that
// retires one quotient bit per cycle, and the product comes from a shift-and-add
// multiplier that takes one bit of the second operand per cycle; these two iterative
// units set the time a transaction takes. One transaction is worked on at a time.

module lcm_by_euclid_gcd (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   input  wire  [lcm_pkg::DATA_WIDTH-1:0] req_first_value,
   input  wire  [lcm_pkg::DATA_WIDTH-1:0] req_second_value,
   output logic                           rsp_strobe,
   output logic [lcm_pkg::DATA_WIDTH-1:0] rsp_multiple_low,
   output logic                           rsp_multiple_overflow,
   output logic [lcm_pkg::OP_WIDTH-1:0]   rsp_common_divisor
);

   lcm_pkg::dp_cmd_type    cmd;
   lcm_pkg::dp_status_type status;

   // The controller sequences the check, the Euclid iterations, the final divide and
   // the multiply, and raises the strobe for one cycle when the result is ready.
   lcm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .cmd        (cmd),
      .status     (status)
   );

   // The datapath holds the operands, the divider and the multiplier. Its result
   // registers stay put while the strobe is high, since nothing new is loaded then.
   lcm_dp u_dp (
      .clock             (clock),
      .first_value       (req_first_value),
      .second_value      (req_second_value),
      .cmd               (cmd),
      .status            (status),
      .multiple_low      (rsp_multiple_low),
      .multiple_overflow (rsp_multiple_overflow),
      .common_divisor    (rsp_common_divisor)
   );

endmodule

`default_nettype wire

// File: rtl/lcm_dp.sv
`default_nettype none

module lcm_dp (
   input  wire                             clock,
   input  wire  [lcm_pkg::DATA_WIDTH-1:0]  first_value,
   input  wire  [lcm_pkg::DATA_WIDTH-1:0]  second_value,
   input  wire  lcm_pkg::dp_cmd_type       cmd,
   output lcm_pkg::dp_status_type          status,
   output logic [lcm_pkg::DATA_WIDTH-1:0]  multiple_low,
   output logic                            multiple_overflow,
   output logic [lcm_pkg::OP_WIDTH-1:0]    common_divisor
);

   localparam int OPW = lcm_pkg::OP_WIDTH;
   localparam int PW  = lcm_pkg::PROD_WIDTH;
   localparam int DW  = lcm_pkg::DATA_WIDTH;

   logic [OPW-1:0] a_ff, a_in, b_ff, b_in;
   logic [OPW-1:0] x_ff, x_in, y_ff, y_in;
   logic [OPW-1:0] dsr_ff, dsr_in, rem_ff, rem_in, quo_ff, quo_in;
   logic [OPW-1:0] mplier_ff, mplier_in;
   logic [PW-1:0]  mcand_ff, mcand_in, acc_ff, acc_in;
   logic           ok_ff, ok_in;

   logic [OPW+1:0] diff;
   logic           neg;

   // One restoring division step: bring down the next dividend bit and try the divisor.
   assign diff = {1'b0, rem_ff, quo_ff[OPW-1]} - {2'b00, dsr_ff};
   assign neg  = diff[OPW+1];

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      dsr_in    = dsr_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      mplier_in = mplier_ff;
      mcand_in  = mcand_ff;
      acc_in    = acc_ff;
      ok_in     = ok_ff;

      if (cmd.load) begin
         a_in  = first_value[OPW-1:0];
         b_in  = second_value[OPW-1:0];
         x_in  = first_value[OPW-1:0];
         y_in  = second_value[OPW-1:0];
         ok_in = (first_value != '0) && !first_value[DW-1] &&
                 (second_value != '0) && !second_value[DW-1];
      end
      if (cmd.clear) begin
         acc_in = '0;
         x_in   = '0;
      end
      if (cmd.gdiv_init) begin
         quo_in = x_ff;
         dsr_in = y_ff;
         rem_in = '0;
      end
      if (cmd.qdiv_init) begin
         quo_in = a_ff;
         dsr_in = x_ff;
         rem_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = neg ? {rem_ff[OPW-2:0], quo_ff[OPW-1]} : diff[OPW-1:0];
         quo_in = {quo_ff[OPW-2:0], ~neg};
      end
      if (cmd.gcd_shift) begin
         x_in = y_ff;
         y_in = rem_ff;
      end
      if (cmd.mul_init) begin
         mcand_in  = {{(PW-OPW){1'b0}}, quo_ff};
         mplier_in = b_ff;
         acc_in    = '0;
      end
      if (cmd.mul_step) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = {mcand_ff[PW-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[OPW-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      dsr_ff    <= dsr_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      mplier_ff <= mplier_in;
      mcand_ff  <= mcand_in;
      acc_ff    <= acc_in;
      ok_ff     <= ok_in;
   end

   assign status.operands_ok = ok_ff;
   assign status.y_zero      = (y_ff == '0);

   assign multiple_low      = acc_ff[DW-1:0];
   assign multiple_overflow = |acc_ff[PW-1:DW];
   assign common_divisor    = x_ff;

endmodule

`default_nettype wire

// File: rtl/lcm_ctrl.sv
`default_nettype none

module lcm_ctrl (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   output logic                           busy,
   output logic                           rsp_strobe,
   output lcm_pkg::dp_cmd_type            cmd,
   input  wire  lcm_pkg::dp_status_type   status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_GDIV,
      ST_GNEXT,
      ST_CHOOSE,
      ST_QDIV,
      ST_MUL,
      ST_RESP
   } state_type;

   state_type                       state_ff, state_in;
   logic [lcm_pkg::CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            strobe_ff, strobe_in;
   logic                            last;
   // Marks that the multiplier operands have been loaded for this transaction.
   logic                            mul_loaded_ff, mul_loaded_in;

   assign last = (cnt_ff == lcm_pkg::LAST_STEP);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      strobe_in = 1'b0;
      cmd       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               busy_in  = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.operands_ok) begin
               cmd.gdiv_init = 1'b1;
               cnt_in        = '0;
               state_in      = ST_GDIV;
            end else begin
               cmd.clear = 1'b1;
               strobe_in = 1'b1;
               state_in  = ST_RESP;
            end
         end
         ST_GDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_GNEXT;
            end
         end
         ST_GNEXT: begin
            cmd.gcd_shift = 1'b1;
            state_in      = ST_CHOOSE;
         end
         ST_CHOOSE: begin
            cnt_in = '0;
            if (status.y_zero) begin
               cmd.qdiv_init = 1'b1;
               state_in      = ST_QDIV;
            end else begin
               cmd.gdiv_init = 1'b1;
               state_in      = ST_GDIV;
            end
         end
         ST_QDIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (last) begin
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // The first cycle here loads the multiplier, the rest add one bit each.
            if (!mul_loaded_ff) begin
               cmd.mul_init = 1'b1;
            end else begin
               cmd.mul_step = 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               if (last) begin
                  strobe_in = 1'b1;
                  state_in  = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            busy_in  = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      mul_loaded_in = mul_loaded_ff;
      if (cmd.mul_init) begin
         mul_loaded_in = 1'b1;
      end else if (cmd.load) begin
         mul_loaded_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         busy_ff       <= 1'b0;
         strobe_ff     <= 1'b0;
         mul_loaded_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         busy_ff       <= busy_in;
         strobe_ff     <= strobe_in;
         mul_loaded_ff <= mul_loaded_in;
      end
   end

   assign busy       = busy_ff;
   assign rsp_strobe = strobe_ff;

endmodule

`default_nettype wire
